>>> design/dqd_pkg.sv
// Shared types and constants for the deque with delete-by-value.
package dqd_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CMD_W          = 3;
    localparam int VALUE_W        = 32;
    localparam int STATUS_W       = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_POP_BACK   = 3'd1,
        CMD_PUSH_FRONT = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_DELETE     = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOMATCH = 2'd3
    } t_status;

    // Per-cycle operation strobes broadcast to every cell; already qualified.
    typedef struct packed {
        logic push_back;
        logic pop_back;
        logic push_front;
        logic pop_front;
        logic del;
    } t_cell_ctrl;

endpackage

>>> design/dqd_cmd_if.sv
// Command request channel: valid/ready with command and value.
interface dqd_cmd_if import dqd_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

>>> design/dqd_res_if.sv
// Result request channel: valid/ready with popped value, status and count.
interface dqd_res_if import dqd_pkg::*; #(
    parameter int CNT_W = 5
);
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  popped_value;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    entry_count;

    modport source (output valid, output popped_value, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input popped_value, input status, input entry_count,
                    output ready);
endinterface

>>> design/dqd_cell.sv
// One storage cell of the deque: holds one word and its valid bit.
module dqd_cell import dqd_pkg::*; #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cell_ctrl   i_ctrl,
    input  logic [W-1:0] i_new,
    input  logic [W-1:0] i_left_data,
    input  logic         i_left_valid,
    input  logic [W-1:0] i_right_data,
    input  logic         i_right_valid,
    input  logic         i_hit,
    input  logic [W-1:0] i_tap,
    output logic         o_hit,
    output logic [W-1:0] o_tap,
    output logic [W-1:0] o_data,
    output logic         o_valid
);

    logic [W-1:0] r_data, n_data;
    logic         r_valid, n_valid;
    logic         w_match, w_last;

    assign w_match = r_valid && (r_data == i_new);
    assign w_last  = r_valid && !i_right_valid;
    // first match ripples toward the back; this cell and all behind it close the gap
    assign o_hit   = i_hit || w_match;
    // tap chain carries the back entry out at the back end for a pop from the back
    assign o_tap   = i_tap | (w_last ? r_data : '0);
    assign o_data  = r_data;
    assign o_valid = r_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctrl.push_back && !r_valid && i_left_valid) begin
            n_data  = i_new;
            n_valid = 1'b1;
        end
        if (i_ctrl.pop_back && w_last) begin
            n_valid = 1'b0;
        end
        if (i_ctrl.push_front) begin
            n_data  = i_left_data;
            n_valid = i_left_valid;
        end
        if (i_ctrl.pop_front || (i_ctrl.del && o_hit)) begin
            n_data  = i_right_data;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

>>> design/deque_with_delete_by_value_top.sv
// Top level of the deque with delete-by-value: cell chain, decode and result register.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+-----------------------------------------
//  i_cmd    | in  | valid / ready  | command, value
//  o_res    | out | valid / ready  | popped_value, status, entry_count
//
// One command per cycle while the result is taken; its result appears in the cycle
// after acceptance. Every cell compares, shifts and drops in parallel; the match and
// pop-back taps ripple once through the cell row inside that cycle.
// Reset clears all cell valid bits, the count and the result valid bit at once.
// A result not taken holds the input off until the result register frees up.
module deque_with_delete_by_value_top import dqd_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dqd_cmd_if.sink   i_cmd,
    dqd_res_if.source o_res
);

    localparam int KEEP_W = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

    logic [KEEP_W-1:0] w_new;
    logic [KEEP_W-1:0] c_data  [CAPACITY];
    logic              c_valid [CAPACITY];
    logic              c_hit   [CAPACITY+1];
    logic [KEEP_W-1:0] c_tap   [CAPACITY+1];

    logic       w_accept, w_full, w_empty, w_found;
    t_cell_ctrl w_ctrl;
    t_status    w_status;
    logic [KEEP_W-1:0] w_popped;
    logic [CNT_W-1:0]  r_count, n_count;

    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_popped;
    t_status             r_status;

    assign w_new    = KEEP_W'(i_cmd.value);
    assign w_accept = i_cmd.valid && i_cmd.ready;
    assign w_full   = c_valid[CAPACITY-1];
    assign w_empty  = !c_valid[0];
    assign w_found  = c_hit[CAPACITY];

    assign c_hit[0] = 1'b0;
    assign c_tap[0] = '0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [KEEP_W-1:0] w_ld, w_rd;
            logic              w_lv, w_rv;
            if (g == 0) begin : g_head
                assign w_ld = w_new;
                assign w_lv = 1'b1;
            end else begin : g_mid
                assign w_ld = c_data[g-1];
                assign w_lv = c_valid[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign w_rd = '0;
                assign w_rv = 1'b0;
            end else begin : g_body
                assign w_rd = c_data[g+1];
                assign w_rv = c_valid[g+1];
            end
            dqd_cell #(.W(KEEP_W)) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_new         (w_new),
                .i_left_data   (w_ld),
                .i_left_valid  (w_lv),
                .i_right_data  (w_rd),
                .i_right_valid (w_rv),
                .i_hit         (c_hit[g]),
                .i_tap         (c_tap[g]),
                .o_hit         (c_hit[g+1]),
                .o_tap         (c_tap[g+1]),
                .o_data        (c_data[g]),
                .o_valid       (c_valid[g])
            );
        end
    endgenerate

    always_comb begin
        w_ctrl   = '0;
        w_status = ST_OK;
        w_popped = '0;
        n_count  = r_count;
        case (t_cmd'(i_cmd.command))
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctrl.push_back  = w_accept && (t_cmd'(i_cmd.command) == CMD_PUSH_BACK);
                    w_ctrl.push_front = w_accept && (t_cmd'(i_cmd.command) == CMD_PUSH_FRONT);
                    n_count = r_count + 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_ctrl.pop_back = w_accept;
                    w_popped = c_tap[CAPACITY];
                    n_count  = r_count - 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_ctrl.pop_front = w_accept;
                    w_popped = c_data[0];
                    n_count  = r_count - 1'b1;
                end
            end
            CMD_DELETE: begin
                if (!w_found) begin
                    w_status = ST_NOMATCH;
                end else begin
                    w_ctrl.del = w_accept;
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign i_cmd.ready        = !r_out_valid || o_res.ready;
    assign o_res.valid        = r_out_valid;
    assign o_res.popped_value = r_popped;
    assign o_res.status       = r_status;
    assign o_res.entry_count  = r_count;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_popped <= VALUE_W'(w_popped);
            r_status <= w_status;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> design/dqd_checker.sv
// Port-level checks for the deque top level, bound to it.
module dqd_checker import dqd_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_res_valid,
    input logic                i_res_ready,
    input logic [VALUE_W-1:0]  i_popped_value,
    input logic [STATUS_W-1:0] i_status,
    input logic [CNT_W-1:0]    i_entry_count
);

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_status == ST_FULL) |-> i_entry_count == CNT_W'(CAPACITY))
        else $error("full status with count below capacity");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_status == ST_EMPTY) |-> i_entry_count == '0)
        else $error("empty status with nonzero count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_entry_count <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_status != ST_OK) |-> i_popped_value == '0)
        else $error("refused request returned a word");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_entry_count))
        else $error("stalled result dropped or changed");

endmodule

bind deque_with_delete_by_value_top dqd_checker #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
) u_dqd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_popped_value (o_res.popped_value),
    .i_status       (o_res.status),
    .i_entry_count  (o_res.entry_count)
);

>>> verif/deque_with_delete_by_value_top_tb.sv
// Testbench for the deque with delete-by-value: directed table, random requests, scoreboard.
`timescale 1ns / 100ps

module deque_with_delete_by_value_top_tb;
    import dqd_pkg::*;

    localparam int CNT_W        = $clog2(CAPACITY_DEF + 1);
    localparam int RANDOM_ITEMS = 1760;
    localparam int QUIET_TAIL   = 150;
    localparam int DRAIN_CYCLES = 10;
    localparam int STALL_LIMIT  = 500;
    localparam int MAX_REPORTS  = 10;

    // command codes the block decodes as no-ops
    localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    localparam logic [VALUE_W-1:0] FILL_WORD = 32'hA5A5_A5A5;
    localparam logic [VALUE_W-1:0] ALL_ONES  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [VALUE_W-1:0] popped_value;
        t_status            status;
        logic [CNT_W-1:0]   entry_count;
    } t_deque_result;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
        int                 reps;
        bit                 typed;
        t_deque_result      res;
    } t_deque_request;

    logic i_clk;
    logic i_rst_n;

    dqd_cmd_if                  cmd_ch ();
    dqd_res_if #(.CNT_W(CNT_W)) res_ch ();

    deque_with_delete_by_value_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    // Directed requests; typed results only where they are obvious.
    t_deque_request directed_rows[] = '{
        '{CMD_POP_BACK,   32'h0,        1,  1'b1, '{32'h0, ST_EMPTY,   5'd0}},
        '{CMD_POP_FRONT,  32'h0,        1,  1'b1, '{32'h0, ST_EMPTY,   5'd0}},
        '{CMD_DELETE,     32'h0,        1,  1'b1, '{32'h0, ST_NOMATCH, 5'd0}},
        '{CMD_RSVD_5,     32'h0,        1,  1'b1, '{32'h0, ST_OK,      5'd0}},
        '{CMD_RSVD_7,     ALL_ONES,     1,  1'b1, '{32'h0, ST_OK,      5'd0}},
        '{CMD_PUSH_BACK,  ALL_ONES,     1,  1'b1, '{32'h0, ST_OK,      5'd1}},
        '{CMD_PUSH_FRONT, 32'h0,        1,  1'b1, '{32'h0, ST_OK,      5'd2}},
        '{CMD_PUSH_BACK,  32'h0,        1,  1'b0, '0},
        '{CMD_DELETE,     32'h0,        1,  1'b0, '0},
        '{CMD_POP_FRONT,  32'h5,        1,  1'b0, '0},
        '{CMD_RSVD_6,     32'h1234_5678, 1, 1'b0, '0},
        '{CMD_PUSH_FRONT, FILL_WORD,    15, 1'b0, '0},
        '{CMD_PUSH_BACK,  32'h1,        1,  1'b1, '{32'h0, ST_FULL,    5'd16}},
        '{CMD_PUSH_FRONT, 32'h2,        1,  1'b1, '{32'h0, ST_FULL,    5'd16}},
        '{CMD_DELETE,     32'h0,        1,  1'b0, '0},
        '{CMD_DELETE,     32'hDEAD_BEEF, 1, 1'b1, '{32'h0, ST_NOMATCH, 5'd15}},
        '{CMD_DELETE,     FILL_WORD,    1,  1'b0, '0},
        '{CMD_POP_BACK,   32'h0,        1,  1'b0, '0}
    };

    t_deque_request     stim_q[$];
    t_deque_request     cur_req;
    t_deque_result      pending_results[$];
    logic [VALUE_W-1:0] held_words[$];

    int req_idx;
    int errors;
    int send_gap, recv_gap;
    int cmd_phase_left, res_phase_left;
    int cmd_idle_pct, res_idle_pct;
    int stall_cycles;
    int idle_odds[3] = '{0, 10, 30};

    always #6 i_clk = ~i_clk;

    // Expected outcome of one command; updates the held words.
    function automatic t_deque_result apply_command(logic [CMD_W-1:0] cmd,
                                                    logic [VALUE_W-1:0] value);
        t_deque_result r;
        int            hit;
        r.popped_value = '0;
        r.status       = ST_OK;
        hit            = -1;
        case (cmd)
            CMD_PUSH_BACK: begin
                if (held_words.size() >= CAPACITY_DEF) r.status = ST_FULL;
                else held_words.push_back(value);
            end
            CMD_PUSH_FRONT: begin
                if (held_words.size() >= CAPACITY_DEF) r.status = ST_FULL;
                else held_words.push_front(value);
            end
            CMD_POP_BACK: begin
                if (held_words.size() == 0) r.status = ST_EMPTY;
                else r.popped_value = held_words.pop_back();
            end
            CMD_POP_FRONT: begin
                if (held_words.size() == 0) r.status = ST_EMPTY;
                else r.popped_value = held_words.pop_front();
            end
            CMD_DELETE: begin
                foreach (held_words[i])
                    if (hit < 0 && held_words[i] == value) hit = i;
                if (hit < 0) r.status = ST_NOMATCH;
                else held_words.delete(hit);
            end
            default: ;
        endcase
        r.entry_count = CNT_W'(held_words.size());
        return r;
    endfunction

    task automatic build_stimulus();
        t_deque_request     req;
        logic [VALUE_W-1:0] word_pool[8];
        int                 push_odds[4]   = '{70, 20, 40, 35};
        int                 delete_odds[4] = '{10, 10, 20, 40};
        int                 counted;
        int                 mode;
        int                 mode_left;
        int                 pick;
        foreach (directed_rows[r])
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                req       = directed_rows[r];
                req.typed = directed_rows[r].typed && directed_rows[r].reps == 1;
                stim_q.push_back(req);
            end
        // small pool of words so deletes hit, often with duplicates held
        word_pool[0] = '0;
        word_pool[1] = ALL_ONES;
        for (int k = 2; k < 8; k++) word_pool[k] = $urandom;
        counted   = 0;
        mode      = 0;
        mode_left = 0;
        while (counted < RANDOM_ITEMS) begin
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 48);
            end
            mode_left--;
            req.typed = 1'b0;
            req.reps  = 1;
            req.res   = '0;
            req.value = $urandom;
            if ($urandom_range(0, 99) < 3) begin
                req.cmd = CMD_W'($urandom_range(CMD_RSVD_5, CMD_RSVD_7));
            end else begin
                counted++;
                pick = $urandom_range(0, 99);
                if (pick < push_odds[mode])
                    req.cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                else if (pick < push_odds[mode] + delete_odds[mode])
                    req.cmd = CMD_DELETE;
                else
                    req.cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
                if (req.cmd != CMD_POP_BACK && req.cmd != CMD_POP_FRONT &&
                    $urandom_range(0, 99) < 60)
                    req.value = word_pool[$urandom_range(0, 7)];
            end
            stim_q.push_back(req);
        end
    endtask

    // Request side: predicts on acceptance, then offers the next request.
    always @(posedge i_clk) begin : cmd_driver
        t_deque_result predicted;
        bit            take;
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else begin
            take = cmd_ch.valid && cmd_ch.ready;
            if (take) begin
                predicted = apply_command(cmd_ch.command, cmd_ch.value);
                pending_results.push_back(cur_req.typed ? cur_req.res : predicted);
                req_idx++;
            end
            if (cmd_phase_left == 0) begin
                cmd_phase_left = $urandom_range(16, 96);
                cmd_idle_pct   = idle_odds[$urandom_range(0, 2)];
            end
            cmd_phase_left--;
            if (take || !cmd_ch.valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                    cmd_ch.valid <= 1'b0;
                end else if (req_idx >= stim_q.size()) begin
                    cmd_ch.valid <= 1'b0;
                end else if (req_idx + QUIET_TAIL < stim_q.size() &&
                             $urandom_range(1, 100) <= cmd_idle_pct) begin
                    send_gap     = $urandom_range(0, 5);
                    cmd_ch.valid <= 1'b0;
                end else begin
                    cmd_ch.valid   <= 1'b1;
                    cmd_ch.command <= stim_q[req_idx].cmd;
                    cmd_ch.value   <= stim_q[req_idx].value;
                    cur_req        <= stim_q[req_idx];
                end
            end
        end
    end

    // Result side: scoreboard check and random back-pressure.
    always @(posedge i_clk) begin : res_checker
        t_deque_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result pop=%h st=%0d cnt=%0d", $realtime,
                                 res_ch.popped_value, res_ch.status, res_ch.entry_count);
                end else begin
                    want = pending_results.pop_front();
                    if (res_ch.popped_value !== want.popped_value ||
                        res_ch.status !== want.status ||
                        res_ch.entry_count !== want.entry_count) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display({"%0t: mismatch exp pop=%h st=%0d cnt=%0d,",
                                      " got pop=%h st=%0d cnt=%0d"},
                                     $realtime, want.popped_value, want.status,
                                     want.entry_count, res_ch.popped_value, res_ch.status,
                                     res_ch.entry_count);
                    end
                end
            end
            if (res_phase_left == 0) begin
                res_phase_left = $urandom_range(16, 96);
                res_idle_pct   = idle_odds[$urandom_range(0, 2)];
            end
            res_phase_left--;
            if (recv_gap > 0) begin
                recv_gap--;
                res_ch.ready <= 1'b0;
            end else if (req_idx + QUIET_TAIL < stim_q.size() &&
                         $urandom_range(1, 100) <= res_idle_pct) begin
                recv_gap     = $urandom_range(0, 5);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.command = '0;
        cmd_ch.value   = '0;
        res_ch.ready   = 1'b0;
        req_idx        = 0;
        errors         = 0;
        send_gap       = 0;
        recv_gap       = 0;
        cmd_phase_left = 0;
        res_phase_left = 0;
        cmd_idle_pct   = 0;
        res_idle_pct   = 0;
        stall_cycles   = 0;
        build_stimulus();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (req_idx < stim_q.size() || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
